/* src/gce_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gce_pkg
// Shared types, constants and helpers of the bitmap glyph color expander.
// ----------------------------------------------------------------------------
package gce_pkg;

	localparam int FRAC_BITS      = 4;
	localparam int MAX_GLYPH_SIDE = 1023;
	localparam int MAX_FB_SIDE    = 4096;

	localparam int COORD_W  = 17;
	localparam int PIXC_W   = COORD_W - FRAC_BITS;
	localparam int ORG_W    = PIXC_W + 1;
	localparam int XW       = ORG_W + 1;
	localparam int SIDE_W   = 10;
	localparam int FB_W     = 13;
	localparam int POS_W    = 12;
	localparam int ADDR_W   = 24;
	localparam int COLOUR_W = 32;

	typedef enum logic [1:0] {
		ACT_SET_POS     = 2'd0,
		ACT_BEGIN_GLYPH = 2'd1,
		ACT_DATA_BYTE   = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		CFG_FB_WIDTH     = 2'd0,
		CFG_FB_HEIGHT    = 2'd1,
		CFG_UNPACK_ALIGN = 2'd2
	} cfg_reg_t;

	// one bitmap byte after clipping, ready for expansion
	typedef struct packed {
		logic [7:0]              mask;
		logic signed [XW-1:0]    x0;
		logic [POS_W-1:0]        row;
		logic [COLOUR_W-1:0]     colour;
	} byte_job_t;

	// fixed point to whole pixels, truncating toward zero
	function automatic logic signed [PIXC_W-1:0] to_pixels(input logic signed [COORD_W-1:0] v);
		logic signed [COORD_W-1:0] bias;
		logic signed [COORD_W-1:0] sum;
		logic signed [COORD_W-1:0] shifted;
		bias = (COORD_W'(1) <<< FRAC_BITS) - COORD_W'(1);
		sum = v[COORD_W-1] ? v + bias : v;
		shifted = sum >>> FRAC_BITS;
		return shifted[PIXC_W-1:0];
	endfunction

	// saturate a grown sum back into the coordinate range
	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [COORD_W:0] v);
		logic signed [COORD_W-1:0] res;
		if (v[COORD_W] != v[COORD_W-1]) begin
			res = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		end else begin
			res = v[COORD_W-1:0];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

/* src/bitmap_glyph_color_expander.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_glyph_color_expander
// Expands one-bit-per-pixel glyph bitmaps into clipped color pixel writes.
// ----------------------------------------------------------------------------
// An item is taken every cycle while the input register is empty or the
// stage behind it has room. set_position, begin_glyph and bitmap bytes with
// no visible set pixel never enter the input register and produce nothing; a
// byte with n visible pixels (up to 8) makes n writes on the single pixel
// write port, one write per cycle while the port is not stalled, leftmost
// pixel first. A taken byte moves from the input register into the expander
// (which forms the row times width product) and then to the output register.
module bitmap_glyph_color_expander (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write_en,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [gce_pkg::FB_W-1:0]          cfg_data,
	input  wire logic                              item_valid,
	output logic                                   item_stall,
	input  wire logic [1:0]                        action,
	input  wire logic signed [gce_pkg::COORD_W-1:0] raster_x,
	input  wire logic signed [gce_pkg::COORD_W-1:0] raster_y,
	input  wire logic                              position_valid,
	input  wire logic [gce_pkg::COLOUR_W-1:0]      colour_argb,
	input  wire logic [gce_pkg::SIDE_W-1:0]        glyph_width,
	input  wire logic [gce_pkg::SIDE_W-1:0]        glyph_height,
	input  wire logic signed [gce_pkg::COORD_W-1:0] orig_x,
	input  wire logic signed [gce_pkg::COORD_W-1:0] orig_y,
	input  wire logic signed [gce_pkg::COORD_W-1:0] move_x,
	input  wire logic signed [gce_pkg::COORD_W-1:0] move_y,
	input  wire logic [7:0]                        data_byte,
	output logic                                   pixel_valid,
	input  wire logic                              pixel_stall,
	output logic [gce_pkg::POS_W-1:0]              pixel_column,
	output logic [gce_pkg::POS_W-1:0]              pixel_row,
	output logic [gce_pkg::ADDR_W-1:0]             pixel_address,
	output logic [gce_pkg::COLOUR_W-1:0]           pixel_colour,
	output logic                                   last
);
	import gce_pkg::*;

	// configuration
	logic [FB_W-1:0]            fb_width_q;
	logic [FB_W-1:0]            fb_height_q;
	logic [3:0]                 unpack_alignment_q;

	// raster and glyph state
	logic signed [COORD_W-1:0]  pos_x_q, pos_y_q;
	logic                       pos_valid_q;
	logic [COLOUR_W-1:0]        draw_colour_q;
	logic signed [ORG_W-1:0]    origin_x_q, origin_y_q;
	logic [SIDE_W-1:0]          cur_width_q, cur_height_q;
	logic signed [COORD_W-1:0]  advance_x_q, advance_y_q;
	logic [SIDE_W-1:0]          byte_in_row_q, row_index_q;
	logic                       glyph_active_q;

	logic                       v_s1;
	byte_job_t                  job_s1;
	logic                       job_ready;

	logic                       accept;
	logic [FB_W-1:0]            fw, fh;
	logic [3:0]                 align;
	logic [SIDE_W:0]            width_round;
	logic [8:0]                 stride;
	logic [SIDE_W-1:0]          gw_clamp, gh_clamp;
	logic signed [ORG_W-1:0]    new_origin_x, new_origin_y;
	logic signed [XW-1:0]       x0;
	logic signed [XW-1:0]       y_cur;
	logic                       y_ok;
	logic signed [XW-1:0]       x_k [8];
	logic [FB_W-1:0]            sx_k [8];
	logic [7:0]                 mask;
	logic [FB_W-1:0]            row_full;
	logic [SIDE_W-1:0]          byte_next, row_next;
	logic signed [COORD_W-1:0]  fin_x_data, fin_y_data, fin_x_new, fin_y_new;

	assign accept = item_valid && !item_stall;
	assign item_stall = v_s1 && !job_ready;

	always_comb begin
		fw = (fb_width_q > FB_W'(MAX_FB_SIDE)) ? FB_W'(MAX_FB_SIDE) : fb_width_q;
		fh = (fb_height_q > FB_W'(MAX_FB_SIDE)) ? FB_W'(MAX_FB_SIDE) : fb_height_q;

		case (unpack_alignment_q) inside
			4'd1, 4'd2, 4'd4, 4'd8: align = unpack_alignment_q;
			default:                align = 4'd1;
		endcase
		width_round = {1'b0, cur_width_q} + (SIDE_W+1)'(7);
		stride = ({1'b0, width_round[SIDE_W:3]} + {5'b0, align} - 9'd1)
			& ~({5'b0, align} - 9'd1);

		gw_clamp = (glyph_width > SIDE_W'(MAX_GLYPH_SIDE)) ? SIDE_W'(MAX_GLYPH_SIDE) : glyph_width;
		gh_clamp = (glyph_height > SIDE_W'(MAX_GLYPH_SIDE)) ? SIDE_W'(MAX_GLYPH_SIDE) : glyph_height;
		new_origin_x = ORG_W'(to_pixels(pos_x_q)) - ORG_W'(to_pixels(orig_x));
		new_origin_y = ORG_W'(to_pixels(pos_y_q)) - ORG_W'(to_pixels(orig_y));

		// per-bit clipping of the incoming byte
		x0 = XW'(origin_x_q) + $signed({{(XW-SIDE_W-3){1'b0}}, byte_in_row_q, 3'b000});
		y_cur = XW'(origin_y_q) + $signed({{(XW-SIDE_W){1'b0}}, row_index_q});
		y_ok = !y_cur[XW-1] && (y_cur[XW-2:0] < {1'b0, fh});
		row_full = fh - FB_W'(1) - y_cur[FB_W-1:0];
		for (int k = 0; k < 8; k++) begin
			sx_k[k] = {byte_in_row_q, 3'(k)};
			x_k[k] = x0 + $signed(XW'(k));
			mask[k] = glyph_active_q && pos_valid_q && data_byte[7-k] && y_ok
				&& (sx_k[k] < {3'b000, cur_width_q})
				&& !x_k[k][XW-1] && (x_k[k][XW-2:0] < {1'b0, fw});
		end

		byte_next = byte_in_row_q + SIDE_W'(1);
		row_next = row_index_q + SIDE_W'(1);
		fin_x_data = sat_coord((COORD_W+1)'(pos_x_q) + (COORD_W+1)'(advance_x_q));
		fin_y_data = sat_coord((COORD_W+1)'(pos_y_q) + (COORD_W+1)'(advance_y_q));
		fin_x_new = sat_coord((COORD_W+1)'(pos_x_q) + (COORD_W+1)'(move_x));
		fin_y_new = sat_coord((COORD_W+1)'(pos_y_q) + (COORD_W+1)'(move_y));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_width_q <= FB_W'(640);
			fb_height_q <= FB_W'(480);
			unpack_alignment_q <= 4'd4;
		end else if (cfg_write_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FB_WIDTH:     fb_width_q <= cfg_data;
				CFG_FB_HEIGHT:    fb_height_q <= cfg_data;
				CFG_UNPACK_ALIGN: unpack_alignment_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_valid_q <= 1'b1;
			draw_colour_q <= 32'hFF00_0000;
			origin_x_q <= '0;
			origin_y_q <= '0;
			cur_width_q <= '0;
			cur_height_q <= '0;
			advance_x_q <= '0;
			advance_y_q <= '0;
			byte_in_row_q <= '0;
			row_index_q <= '0;
			glyph_active_q <= 1'b0;
		end else if (accept) begin
			unique case (action_t'(action))
				ACT_SET_POS: begin
					pos_x_q <= raster_x;
					pos_y_q <= raster_y;
					pos_valid_q <= position_valid;
					draw_colour_q <= colour_argb;
				end
				ACT_BEGIN_GLYPH: begin
					cur_width_q <= gw_clamp;
					cur_height_q <= gh_clamp;
					origin_x_q <= new_origin_x;
					origin_y_q <= new_origin_y;
					advance_x_q <= move_x;
					advance_y_q <= move_y;
					byte_in_row_q <= '0;
					row_index_q <= '0;
					// empty glyph advances at once
					if (gw_clamp == '0 || gh_clamp == '0) begin
						glyph_active_q <= 1'b0;
						pos_x_q <= fin_x_new;
						pos_y_q <= fin_y_new;
					end else begin
						glyph_active_q <= 1'b1;
					end
				end
				ACT_DATA_BYTE: begin
					if (glyph_active_q) begin
						if ({{(9-SIDE_W+SIDE_W){1'b0}}, byte_next} >= {{(SIDE_W){1'b0}}, stride}) begin
							byte_in_row_q <= '0;
							row_index_q <= row_next;
							if (row_next >= cur_height_q) begin
								glyph_active_q <= 1'b0;
								pos_x_q <= fin_x_data;
								pos_y_q <= fin_y_data;
							end
						end else begin
							byte_in_row_q <= byte_next;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// input register in front of the expander
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept && action == ACT_DATA_BYTE && mask != 8'd0) begin
			v_s1 <= 1'b1;
		end else if (job_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && action == ACT_DATA_BYTE && mask != 8'd0) begin
			job_s1.mask <= mask;
			job_s1.x0 <= x0;
			job_s1.row <= row_full[POS_W-1:0];
			job_s1.colour <= draw_colour_q;
		end
	end

	gce_expander u_expander (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (v_s1),
		.job           (job_s1),
		.job_ready     (job_ready),
		.fw            (fw),
		.pixel_valid   (pixel_valid),
		.pixel_stall   (pixel_stall),
		.pixel_column  (pixel_column),
		.pixel_row     (pixel_row),
		.pixel_address (pixel_address),
		.pixel_colour  (pixel_colour),
		.last          (last)
	);

	a_open_glyph_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		glyph_active_q |-> cur_width_q != '0 && cur_height_q != '0)
		else $error("open glyph has zero size");

	a_row_in_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		glyph_active_q |-> row_index_q < cur_height_q)
		else $error("row index past glyph height");

	a_job_has_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> job_s1.mask != 8'd0)
		else $error("queued byte has no pixels");

endmodule
`default_nettype wire

/* src/gce_expander.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gce_expander
// Turns a clipped byte into pixel writes leftmost first, one per unstalled cycle.
// ----------------------------------------------------------------------------
module gce_expander (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              job_valid,
	input  wire gce_pkg::byte_job_t                job,
	output logic                                   job_ready,
	input  wire logic [gce_pkg::FB_W-1:0]          fw,
	output logic                                   pixel_valid,
	input  wire logic                              pixel_stall,
	output logic [gce_pkg::POS_W-1:0]              pixel_column,
	output logic [gce_pkg::POS_W-1:0]              pixel_row,
	output logic [gce_pkg::ADDR_W-1:0]             pixel_address,
	output logic [gce_pkg::COLOUR_W-1:0]           pixel_colour,
	output logic                                   last
);
	import gce_pkg::*;

	logic                      v_s2;
	logic [7:0]                mask_s2;
	logic signed [XW-1:0]      x0_s2;
	logic [POS_W-1:0]          row_s2;
	logic [ADDR_W-1:0]         rowbase_s2;
	logic [COLOUR_W-1:0]       colour_s2;

	logic [2:0]                k_sel;
	logic [7:0]                mask_rest;
	logic                      last_sel;
	logic                      out_load;
	logic signed [XW-1:0]      col_full;
	logic [ADDR_W-1:0]         addr_sel;
	logic [POS_W+FB_W-1:0]     rowbase_full;

	// lowest set bit is the leftmost remaining pixel
	always_comb begin
		k_sel = 3'd0;
		for (int k = 7; k >= 0; k--) begin
			if (mask_s2[k]) begin
				k_sel = 3'(k);
			end
		end
		mask_rest = mask_s2 & ~(8'b1 << k_sel);
		last_sel = (mask_rest == 8'd0);
		col_full = x0_s2 + $signed({{(XW-3){1'b0}}, k_sel});
		addr_sel = rowbase_s2 + {{(ADDR_W-POS_W){1'b0}}, col_full[POS_W-1:0]};
		out_load = v_s2 && (!pixel_valid || !pixel_stall);
		job_ready = !v_s2 || (out_load && last_sel);
		rowbase_full = job.row * fw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (job_valid && job_ready) begin
			v_s2 <= 1'b1;
		end else if (out_load && last_sel) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			mask_s2    <= job.mask;
			x0_s2      <= job.x0;
			row_s2     <= job.row;
			colour_s2  <= job.colour;
			rowbase_s2 <= rowbase_full[ADDR_W-1:0];
		end else if (out_load) begin
			mask_s2 <= mask_rest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
		end else if (out_load) begin
			pixel_valid <= 1'b1;
		end else if (!pixel_stall) begin
			pixel_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_column  <= col_full[POS_W-1:0];
			pixel_row     <= row_s2;
			pixel_address <= addr_sel;
			pixel_colour  <= colour_s2;
			last          <= last_sel;
		end
	end

	a_busy_has_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> mask_s2 != 8'd0)
		else $error("expander busy with an empty mask");

	a_job_taken: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job_ready |=> v_s2)
		else $error("taken byte did not reach the expander");

	a_column_in_fb: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid |-> {1'b0, pixel_column} < fw)
		else $error("pixel column outside the framebuffer");

endmodule
`default_nettype wire

/* bench/pixel_write_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_write_checker
// Watches the item and pixel channels of the glyph expander, works out the
// pixel writes that each accepted item should cause and compares every
// accepted write, field by field, with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module pixel_write_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write_en,
	input  wire logic [1:0]                         cfg_index,
	input  wire logic [gce_pkg::FB_W-1:0]           cfg_data,
	input  wire logic                               item_valid,
	input  wire logic                               item_stall,
	input  wire logic [1:0]                         action,
	input  wire logic signed [gce_pkg::COORD_W-1:0] raster_x,
	input  wire logic signed [gce_pkg::COORD_W-1:0] raster_y,
	input  wire logic                               position_valid,
	input  wire logic [gce_pkg::COLOUR_W-1:0]       colour_argb,
	input  wire logic [gce_pkg::SIDE_W-1:0]         glyph_width,
	input  wire logic [gce_pkg::SIDE_W-1:0]         glyph_height,
	input  wire logic signed [gce_pkg::COORD_W-1:0] orig_x,
	input  wire logic signed [gce_pkg::COORD_W-1:0] orig_y,
	input  wire logic signed [gce_pkg::COORD_W-1:0] move_x,
	input  wire logic signed [gce_pkg::COORD_W-1:0] move_y,
	input  wire logic [7:0]                         data_byte,
	input  wire logic                               pixel_valid,
	input  wire logic                               pixel_stall,
	input  wire logic [gce_pkg::POS_W-1:0]          pixel_column,
	input  wire logic [gce_pkg::POS_W-1:0]          pixel_row,
	input  wire logic [gce_pkg::ADDR_W-1:0]         pixel_address,
	input  wire logic [gce_pkg::COLOUR_W-1:0]       pixel_colour,
	input  wire logic                               last,
	output int                                      pending,
	output int                                      mismatches
);
	import gce_pkg::*;

	typedef struct packed {
		logic [POS_W-1:0]    column;
		logic [POS_W-1:0]    row;
		logic [ADDR_W-1:0]   address;
		logic [COLOUR_W-1:0] colour;
		logic                last;
	} pixel_write_t;

	pixel_write_t write_q[$];
	int err_cnt;

	logic [FB_W-1:0] fb_w, fb_h;
	logic [3:0] align;

	logic signed [COORD_W-1:0] pos_x, pos_y, adv_x, adv_y;
	logic pos_ok;
	logic [COLOUR_W-1:0] draw_col;
	logic signed [ORG_W-1:0] org_x, org_y;
	logic [SIDE_W-1:0] glyph_w, glyph_h, byte_col, row_idx;
	logic glyph_open;

	// fixed point to whole pixels, toward zero
	function automatic int whole_px(input logic signed [COORD_W-1:0] v);
		int s;
		s = v;
		return s / (1 << FRAC_BITS);
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
		int lo, hi;
		lo = -(1 << (COORD_W - 1));
		hi = (1 << (COORD_W - 1)) - 1;
		if (v < lo) return COORD_W'(lo);
		if (v > hi) return COORD_W'(hi);
		return COORD_W'(v);
	endfunction

	function automatic int padded_row_len();
		int bytes, a;
		bytes = (int'(glyph_w) + 7) / 8;
		a = align;
		if (a != 1 && a != 2 && a != 4 && a != 8) a = 1;
		return (bytes + a - 1) & ~(a - 1);
	endfunction

	task automatic close_glyph();
		pos_x = clamp_coord(int'(pos_x) + int'(adv_x));
		pos_y = clamp_coord(int'(pos_y) + int'(adv_y));
		glyph_open = 1'b0;
	endtask

	task automatic expand_byte();
		int fw, fh, x, y, r, sx, k, hits;
		pixel_write_t hit_buf[8];
		fw = (fb_w > MAX_FB_SIDE) ? MAX_FB_SIDE : int'(fb_w);
		fh = (fb_h > MAX_FB_SIDE) ? MAX_FB_SIDE : int'(fb_h);
		hits = 0;
		if (pos_ok) begin
			for (k = 0; k < 8; k++) begin
				sx = int'(byte_col) * 8 + k;
				if (sx >= int'(glyph_w)) break;
				if (data_byte[7-k]) begin
					x = int'(org_x) + sx;
					y = int'(org_y) + int'(row_idx);
					if (x >= 0 && y >= 0 && x < fw && y < fh) begin
						// rows count from the bottom on input, from the top on output
						r = fh - 1 - y;
						hit_buf[hits].column = POS_W'(x);
						hit_buf[hits].row = POS_W'(r);
						hit_buf[hits].address = ADDR_W'(r * fw + x);
						hit_buf[hits].colour = draw_col;
						hit_buf[hits].last = 1'b0;
						hits++;
					end
				end
			end
		end
		for (k = 0; k < hits; k++) begin
			if (k == hits - 1) hit_buf[k].last = 1'b1;
			write_q.push_back(hit_buf[k]);
		end
		byte_col++;
		if (int'(byte_col) >= padded_row_len()) begin
			byte_col = '0;
			row_idx++;
			if (row_idx >= glyph_h) close_glyph();
		end
	endtask

	task automatic predict_item();
		case (action)
			ACT_SET_POS: begin
				pos_x = raster_x;
				pos_y = raster_y;
				pos_ok = position_valid;
				draw_col = colour_argb;
			end
			ACT_BEGIN_GLYPH: begin
				// an open glyph is dropped here without its advance
				glyph_w = glyph_width;
				glyph_h = glyph_height;
				org_x = ORG_W'(whole_px(pos_x) - whole_px(orig_x));
				org_y = ORG_W'(whole_px(pos_y) - whole_px(orig_y));
				adv_x = move_x;
				adv_y = move_y;
				byte_col = '0;
				row_idx = '0;
				glyph_open = 1'b1;
				if (glyph_w == 0 || glyph_h == 0) close_glyph();
			end
			ACT_DATA_BYTE: begin
				if (glyph_open) expand_byte();
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_write();
		pixel_write_t got, want;
		got = {pixel_column, pixel_row, pixel_address, pixel_colour, last};
		if (write_q.size() == 0) begin
			err_cnt++;
			if (err_cnt <= 10)
				$display("unexpected pixel write: col %0d row %0d addr %0d colour %h last %0d",
					got.column, got.row, got.address, got.colour, got.last);
		end else begin
			want = write_q.pop_front();
			if (got !== want) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display({"pixel write mismatch: expected col %0d row %0d addr %0d colour %h",
						" last %0d, got col %0d row %0d addr %0d colour %h last %0d"},
						want.column, want.row, want.address, want.colour, want.last,
						got.column, got.row, got.address, got.colour, got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_w = FB_W'(640);
			fb_h = FB_W'(480);
			align = 4'd4;
			pos_x = '0;
			pos_y = '0;
			pos_ok = 1'b1;
			draw_col = 32'hFF00_0000;
			org_x = '0;
			org_y = '0;
			glyph_w = '0;
			glyph_h = '0;
			adv_x = '0;
			adv_y = '0;
			byte_col = '0;
			row_idx = '0;
			glyph_open = 1'b0;
			write_q.delete();
			err_cnt = 0;
			pending <= 0;
			mismatches <= 0;
		end else begin
			if (pixel_valid && !pixel_stall) check_write();
			if (cfg_write_en) begin
				case (cfg_index)
					CFG_FB_WIDTH:     fb_w = cfg_data;
					CFG_FB_HEIGHT:    fb_h = cfg_data;
					CFG_UNPACK_ALIGN: align = cfg_data[3:0];
					default: begin
					end
				endcase
			end
			if (item_valid && !item_stall) predict_item();
			pending <= write_q.size();
			mismatches <= err_cnt;
		end
	end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives glyph items and register settings into the color expander, idles
// the item channel and stalls the pixel channel at random and reports the
// verdict from the pixel write checker.
// ----------------------------------------------------------------------------
module tb;
	import gce_pkg::*;

	localparam int IDLE_LIMIT  = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 8;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]                act;
		logic signed [COORD_W-1:0] rx, ry;
		logic                      pv;
		logic [COLOUR_W-1:0]       argb;
		logic [SIDE_W-1:0]         gw, gh;
		logic signed [COORD_W-1:0] ox, oy, mx, my;
		logic [7:0]                db;
	} glyph_item_t;

	logic clk, arst_n;
	logic cfg_write_en;
	logic [1:0] cfg_index;
	logic [FB_W-1:0] cfg_data;
	logic item_valid, item_stall;
	logic [1:0] action;
	logic signed [COORD_W-1:0] raster_x, raster_y;
	logic position_valid;
	logic [COLOUR_W-1:0] colour_argb;
	logic [SIDE_W-1:0] glyph_width, glyph_height;
	logic signed [COORD_W-1:0] orig_x, orig_y, move_x, move_y;
	logic [7:0] data_byte;
	logic pixel_valid, pixel_stall;
	logic [POS_W-1:0] pixel_column, pixel_row;
	logic [ADDR_W-1:0] pixel_address;
	logic [COLOUR_W-1:0] pixel_colour;
	logic last;

	int pending, mismatches;
	int hold_left, quiet_cycles;
	bit tx_gaps, rx_gaps, hold_req;
	int cur_fb_w, cur_fb_h, cur_align;

	bitmap_glyph_color_expander dut (.*);
	pixel_write_checker pix_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// pixel side: random stalls, plus one long hold on request
	initial begin
		pixel_stall <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pixel_stall <= 1'b1;
			end else begin
				pixel_stall <= rx_gaps && ($urandom_range(99) < 35);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (pixel_valid && !pixel_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic glyph_item_t noise_item();
		glyph_item_t it;
		it.act = 2'($urandom_range(3));
		it.rx = COORD_W'($urandom);
		it.ry = COORD_W'($urandom);
		it.pv = 1'($urandom_range(1));
		it.argb = $urandom;
		it.gw = SIDE_W'($urandom);
		it.gh = SIDE_W'($urandom);
		it.ox = COORD_W'($urandom);
		it.oy = COORD_W'($urandom);
		it.mx = COORD_W'($urandom);
		it.my = COORD_W'($urandom);
		it.db = 8'($urandom);
		return it;
	endfunction

	function automatic glyph_item_t mk_pos(input int x, input int y, input bit ok,
			input logic [COLOUR_W-1:0] argb);
		glyph_item_t it;
		it = noise_item();
		it.act = ACT_SET_POS;
		it.rx = COORD_W'(x);
		it.ry = COORD_W'(y);
		it.pv = ok;
		it.argb = argb;
		return it;
	endfunction

	function automatic glyph_item_t mk_glyph(input int w, input int h, input int ox,
			input int oy, input int mx, input int my);
		glyph_item_t it;
		it = noise_item();
		it.act = ACT_BEGIN_GLYPH;
		it.gw = SIDE_W'(w);
		it.gh = SIDE_W'(h);
		it.ox = COORD_W'(ox);
		it.oy = COORD_W'(oy);
		it.mx = COORD_W'(mx);
		it.my = COORD_W'(my);
		return it;
	endfunction

	function automatic glyph_item_t mk_byte(input logic [7:0] db);
		glyph_item_t it;
		it = noise_item();
		it.act = ACT_DATA_BYTE;
		it.db = db;
		return it;
	endfunction

	// whole pixel in [lo, hi] plus a random fraction, now and then anything
	function automatic int pick_coord(input int lo, input int hi);
		int px, frac;
		if ($urandom_range(7) == 0) return int'(COORD_W'($urandom));
		px = lo + int'($urandom_range(hi - lo));
		frac = $urandom_range(15);
		if (px < 0 || (px == 0 && $urandom_range(1) == 1)) return px * 16 - frac;
		return px * 16 + frac;
	endfunction

	function automatic int pick_offset();
		if ($urandom_range(7) == 0) return int'(COORD_W'($urandom));
		return int'($urandom_range(96)) - 48;
	endfunction

	task automatic send_item(input glyph_item_t it);
		while (tx_gaps && $urandom_range(99) < 35) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		action <= it.act;
		raster_x <= it.rx;
		raster_y <= it.ry;
		position_valid <= it.pv;
		colour_argb <= it.argb;
		glyph_width <= it.gw;
		glyph_height <= it.gh;
		orig_x <= it.ox;
		orig_y <= it.oy;
		move_x <= it.mx;
		move_y <= it.my;
		data_byte <= it.db;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic drain(input int settle);
		item_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_regs(input int w, input int h, input int a);
		cfg_write_en <= 1'b1;
		cfg_index <= CFG_FB_WIDTH;
		cfg_data <= FB_W'(w);
		@(posedge clk);
		cfg_index <= CFG_FB_HEIGHT;
		cfg_data <= FB_W'(h);
		@(posedge clk);
		cfg_index <= CFG_UNPACK_ALIGN;
		cfg_data <= FB_W'(a);
		@(posedge clk);
		cfg_write_en <= 1'b0;
		cur_fb_w = w;
		cur_fb_h = h;
		cur_align = a;
	endtask

	// mostly whole glyphs with random content, some cut short or overrun,
	// some stray items
	task automatic run_glyphs(input int count);
		glyph_item_t it;
		int sent, roll, a, stride, total, nbytes, xs, ys;
		sent = 0;
		xs = (cur_fb_w > 4087) ? 4095 : cur_fb_w + 8;
		ys = (cur_fb_h > 4087) ? 4095 : cur_fb_h + 8;
		while (sent < count) begin
			if ($urandom_range(99) < 8) begin
				send_item(noise_item());
			end else begin
				if ($urandom_range(2) != 0) begin
					send_item(mk_pos(pick_coord(-8, xs), pick_coord(-8, ys),
						$urandom_range(9) != 0, $urandom));
					sent++;
				end
				it = mk_glyph(0, 0, pick_offset(), pick_offset(), pick_offset(),
					pick_offset());
				roll = $urandom_range(9);
				it.gw = (roll == 0) ? '0 : (roll < 7) ? SIDE_W'($urandom_range(1, 24)) :
					(roll < 9) ? SIDE_W'($urandom_range(25, 80)) : SIDE_W'($urandom);
				roll = $urandom_range(9);
				it.gh = (roll == 0) ? '0 : (roll < 8) ? SIDE_W'($urandom_range(1, 3)) :
					SIDE_W'($urandom);
				send_item(it);
				sent++;
				if (it.gw != 0 && it.gh != 0) begin
					a = cur_align;
					if (a != 1 && a != 2 && a != 4 && a != 8) a = 1;
					stride = ((int'(it.gw) + 7) / 8 + a - 1) / a * a;
					total = stride * int'(it.gh);
					nbytes = (total > 48) ? int'($urandom_range(1, 12)) : total;
					roll = $urandom_range(9);
					if (roll == 0) nbytes += 2;
					else if (roll == 1 && nbytes > 1) nbytes--;
					repeat (nbytes) begin
						roll = $urandom_range(9);
						send_item(mk_byte((roll < 3) ? 8'hFF : (roll == 3) ? 8'h00 :
							8'($urandom)));
						sent++;
					end
				end
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_write_en <= 1'b0;
		cfg_index <= CFG_FB_WIDTH;
		cfg_data <= '0;
		item_valid <= 1'b0;
		action <= ACT_SET_POS;
		raster_x <= '0;
		raster_y <= '0;
		position_valid <= 1'b0;
		colour_argb <= '0;
		glyph_width <= '0;
		glyph_height <= '0;
		orig_x <= '0;
		orig_y <= '0;
		move_x <= '0;
		move_y <= '0;
		data_byte <= '0;
		hold_req = 1'b0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		cur_fb_w = 640;
		cur_fb_h = 480;
		cur_align = 4;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one row at the bottom left, padding bytes with set bits
		send_item(mk_glyph(8, 1, 0, 0, 160, -32));
		send_item(mk_byte(8'hFF));
		send_item(mk_byte(8'hFF));
		send_item(mk_byte(8'h00));
		send_item(mk_byte(8'h81));
		// stray byte, then the unused action code
		send_item(mk_byte(8'hFF));
		send_item(mk_pos(0, 0, 1'b1, '0));
		begin
			glyph_item_t junk;
			junk = noise_item();
			junk.act = ACT_UNUSED;
			send_item(junk);
		end
		// empty glyph advances at once and saturates both ways
		send_item(mk_pos(-65536, 65535, 1'b1, 32'hFFFF_FFFF));
		send_item(mk_glyph(0, 5, 0, 0, -65536, 65535));
		// invalid position: bytes consumed, nothing drawn
		send_item(mk_pos(-5, 16 * 470 + 9, 1'b0, 32'h1234_5678));
		send_item(mk_glyph(8, 1, -17, 0, 16, 0));
		repeat (4) send_item(mk_byte(8'hFF));
		// new position in the middle of a glyph, then a glyph dropped half way
		send_item(mk_pos(16 * 630 + 3, 16 * 20, 1'b1, 32'h80A0_C0E0));
		send_item(mk_glyph(16, 2, 0, -33, -48, 16));
		send_item(mk_byte(8'hFF));
		send_item(mk_pos(0, 0, 1'b1, 32'h0102_0304));
		send_item(mk_byte(8'hFF));
		send_item(mk_glyph(1, 1, -95, 0, 65535, -65536));
		send_item(mk_byte(8'h80));
		repeat (3) send_item(mk_byte(8'h00));
		drain(SETTLE);

		// hold the pixel side off while a dense glyph streams in
		set_regs(640, 480, 1);
		tx_gaps = 1'b0;
		hold_req = 1'b1;
		send_item(mk_pos(16 * 100, 16 * 100, 1'b1, $urandom));
		send_item(mk_glyph(64, 4, 0, 0, 0, 0));
		repeat (32) send_item(mk_byte(8'hFF));
		drain(SETTLE);
		tx_gaps = 1'b1;

		set_regs(1, 1, 1);
		run_glyphs(10);
		drain(SETTLE);

		set_regs(MAX_FB_SIDE, MAX_FB_SIDE, 8);
		run_glyphs(10);
		// widest glyph, cut short once it has run off the right edge through
		// the last address
		send_item(mk_pos(16 * 4000, 0, 1'b1, $urandom));
		send_item(mk_glyph(MAX_GLYPH_SIDE, 1, 0, 0, 0, 0));
		repeat (16) send_item(mk_byte(8'hFF));
		drain(SETTLE);

		set_regs(8191, 8191, 2);
		run_glyphs(10);
		drain(SETTLE);

		set_regs(0, 0, 15);
		run_glyphs(6);
		drain(SETTLE);

		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		set_regs(37, 23, 5);
		run_glyphs(20);
		drain(SETTLE);
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;

		set_regs(64, 48, 2);
		run_glyphs(12);
		drain(SETTLE);

		set_regs($urandom_range(1, 300), $urandom_range(1, 200), 1 << $urandom_range(3));
		run_glyphs(14);
		drain(20);

		if (mismatches == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* files.f */
src/gce_pkg.sv
src/gce_expander.sv
src/bitmap_glyph_color_expander.sv
bench/pixel_write_checker.sv
bench/tb.sv
